### hw/rtl/text_console_glyph_renderer_top_macros.svh
// Assertion macros shared by the glyph renderer checker.
// Each macro expands to one labeled concurrent assertion that is disabled in reset.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_TOP_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_TOP_MACROS_SVH

// Same-cycle implication.
`define TCGR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tcgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared constants, codes and control types of the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // Block dimensions.
  localparam int CELL_HEIGHT = 16;
  localparam int FONT_DEPTH  = 4096;
  localparam int COORD_BITS  = 12;
  localparam int FONT_AW     = $clog2(FONT_DEPTH);

  // Field widths.
  localparam int OPC_W      = 2;
  localparam int CODE_W     = 8;
  localparam int COLOR_W    = 32;
  localparam int FIDX_W     = 12;
  localparam int GLYPH_W    = 8;
  localparam int ADDR_W     = 25;
  localparam int STRIDE_W   = 14;
  localparam int SCREEN_W   = 13;
  localparam int GROWS_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Glyph geometry: a glyph is at most sixteen rows of eight pixels.
  localparam int CELL_WIDTH = 8;
  localparam int MAX_ROWS   = 16;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int BS_ROWS    = (CELL_HEIGHT < MAX_ROWS) ? CELL_HEIGHT : MAX_ROWS;

  // Width that holds a cursor coordinate plus a cell step and any screen size.
  localparam int CMP_W = (COORD_BITS + 2 > SCREEN_W + 1) ? COORD_BITS + 2 : SCREEN_W + 1;

  // Register reset values.
  localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(1024);
  localparam logic [SCREEN_W-1:0] WIDTH_RST  = SCREEN_W'(1024);
  localparam logic [SCREEN_W-1:0] HEIGHT_RST = SCREEN_W'(768);
  localparam logic [COLOR_W-1:0]  BG_RST     = 32'h0018_2028;
  localparam logic [GROWS_W-1:0]  GROWS_RST  = GROWS_W'(16);

  // Special character codes.
  localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 8'd8;

  typedef enum logic [OPC_W-1:0] {
    OP_PRINT = 2'd0,
    OP_LOAD  = 2'd1,
    OP_HOME  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_STRIDE   = 3'd0,
    REG_SCREEN_WIDTH  = 3'd1,
    REG_SCREEN_HEIGHT = 3'd2,
    REG_BG_COLOR      = 3'd3,
    REG_GLYPH_ROWS    = 3'd4
  } cfg_reg_e;

  // What the latched item asks for.
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_LOAD    = 3'd1,
    KIND_HOME    = 3'd2,
    KIND_NEWLINE = 3'd3,
    KIND_BS      = 3'd4,
    KIND_PRINT   = 3'd5
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic mult;
    logic base;
    logic step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  last;
  } status_t;

  // Reduce a twelve-bit font entry number modulo the font depth.
  function automatic logic [FONT_AW-1:0] font_fold(input logic [FIDX_W-1:0] v);
    logic [FONT_AW+FIDX_W-1:0] t;
    t = (FONT_AW + FIDX_W)'(v);
    return t[FONT_AW-1:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/tcgr_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_ifs
// Valid/ready channel interfaces: input items, row writes and register writes.
// ----------------------------------------------------------------------------
interface tcgr_item_if;
  logic                           valid;
  logic                           ready;
  logic [tcgr_pkg::OPC_W-1:0]     opcode;
  logic [tcgr_pkg::CODE_W-1:0]    char_code;
  logic [tcgr_pkg::COLOR_W-1:0]   text_color;
  logic [tcgr_pkg::FIDX_W-1:0]    font_index;
  logic [tcgr_pkg::GLYPH_W-1:0]   font_byte;

  modport source (output valid, opcode, char_code, text_color, font_index, font_byte,
                  input ready);
  modport sink   (input valid, opcode, char_code, text_color, font_index, font_byte,
                  output ready);
endinterface

interface tcgr_row_if;
  logic                           valid;
  logic                           ready;
  logic [tcgr_pkg::ADDR_W-1:0]    row_address;
  logic [tcgr_pkg::GLYPH_W-1:0]   glyph_bits;
  logic [tcgr_pkg::COLOR_W-1:0]   foreground;
  logic [tcgr_pkg::COLOR_W-1:0]   background;
  logic                           last_row;

  modport source (output valid, row_address, glyph_bits, foreground, background, last_row,
                  input ready);
  modport sink   (input valid, row_address, glyph_bits, foreground, background, last_row,
                  output ready);
endinterface

interface tcgr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tcgr_pkg::CFG_IDX_W-1:0]    index;
  logic [tcgr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/text_console_glyph_renderer_top.sv
// Throughput: one item at a time. A printed character or a backspace passes
// through accept, decode, the row-times-stride multiply and the base add,
// then writes one row beat per cycle while the sink is ready.
// Font loads, home, newline and ignored items pass through accept and decode only.
// Reset: cursor at zero, registers at defaults; the font store is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top
// Text console glyph renderer: turns characters into glyph row writes.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  tcgr_item_if.sink   item_if,
  tcgr_row_if.source  row_if,
  tcgr_cfg_if.sink    cfg_if
);
  import tcgr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Register writes are always taken.
  assign cfg_if.ready = 1'b1;

  tcgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_if.valid),
    .in_ready_o  (item_if.ready),
    .out_valid_o (row_if.valid),
    .out_ready_i (row_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcgr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (item_if.opcode),
    .char_code_i   (item_if.char_code),
    .text_color_i  (item_if.text_color),
    .font_index_i  (item_if.font_index),
    .font_byte_i   (item_if.font_byte),
    .cfg_we_i      (cfg_if.valid),
    .cfg_index_i   (cfg_if.index),
    .cfg_data_i    (cfg_if.data),
    .cmd_i         (cmd),
    .status_o      (status),
    .row_address_o (row_if.row_address),
    .glyph_bits_o  (row_if.glyph_bits),
    .foreground_o  (row_if.foreground),
    .background_o  (row_if.background),
    .last_row_o    (row_if.last_row)
  );

endmodule
`default_nettype wire

### hw/rtl/tcgr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_ctrl
// Controller: sequences decode, base address setup and the row write beats.
// ----------------------------------------------------------------------------
module tcgr_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  input  tcgr_pkg::status_t   status_i,
  output tcgr_pkg::cmd_t      cmd_o
);
  import tcgr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_MULT   = 5'b00100,
    S_ADDR   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Handshake outputs follow the state directly.
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);

  // Commands to the datapath.
  always_comb begin
    cmd_o.capture = in_valid_i && (state_q == S_IDLE);
    cmd_o.exec    = (state_q == S_DECODE);
    cmd_o.mult    = (state_q == S_MULT);
    cmd_o.base    = (state_q == S_ADDR);
    cmd_o.step    = (state_q == S_EMIT) && out_ready_i;
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (status_i.kind == KIND_PRINT || status_i.kind == KIND_BS) begin
          state_d = S_MULT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MULT: state_d = S_ADDR;
      S_ADDR: state_d = S_EMIT;
      S_EMIT: begin
        if (out_ready_i && status_i.last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/tcgr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_dp
// Datapath: registers, cursor, font store, row address stepping and payload.
// ----------------------------------------------------------------------------
module tcgr_dp (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Input item payload.
  input  wire [tcgr_pkg::OPC_W-1:0]         opcode_i,
  input  wire [tcgr_pkg::CODE_W-1:0]        char_code_i,
  input  wire [tcgr_pkg::COLOR_W-1:0]       text_color_i,
  input  wire [tcgr_pkg::FIDX_W-1:0]        font_index_i,
  input  wire [tcgr_pkg::GLYPH_W-1:0]       font_byte_i,
  // Register writes.
  input  wire                               cfg_we_i,
  input  wire [tcgr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [tcgr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Control.
  input  tcgr_pkg::cmd_t                    cmd_i,
  output tcgr_pkg::status_t                 status_o,
  // Row write payload.
  output logic [tcgr_pkg::ADDR_W-1:0]       row_address_o,
  output logic [tcgr_pkg::GLYPH_W-1:0]      glyph_bits_o,
  output logic [tcgr_pkg::COLOR_W-1:0]      foreground_o,
  output logic [tcgr_pkg::COLOR_W-1:0]      background_o,
  output logic                              last_row_o
);
  import tcgr_pkg::*;

  // Latched item.
  logic [OPC_W-1:0]   opcode_q;
  logic [CODE_W-1:0]  code_q;
  logic [COLOR_W-1:0] color_q;
  logic [FIDX_W-1:0]  fidx_q;
  logic [GLYPH_W-1:0] fbyte_q;

  // Configuration registers.
  logic [STRIDE_W-1:0] stride_q;
  logic [SCREEN_W-1:0] width_q;
  logic [SCREEN_W-1:0] height_q;
  logic [COLOR_W-1:0]  bg_q;
  logic [GROWS_W-1:0]  grows_q;

  // Cursor.
  logic [COORD_BITS-1:0] cur_col_q, cur_col_d;
  logic [COORD_BITS-1:0] cur_row_q, cur_row_d;

  // Row sequencing.
  logic [ROW_W-1:0]  rowcnt_q;
  logic [ROW_W-1:0]  nlast_q;
  logic [ROW_W-1:0]  nlast_d;
  logic              is_bs_q;
  logic [ADDR_W-1:0] prod_q;
  logic [ADDR_W-1:0] addr_q;
  logic [COORD_BITS+STRIDE_W-1:0] prod_full;

  // Font store.
  logic [GLYPH_W-1:0] font_mem [FONT_DEPTH];
  logic [GLYPH_W-1:0] glyph_q;
  logic [FONT_AW-1:0] font_ra;
  logic [ROW_W-1:0]   rd_row;
  logic               font_we;

  kind_e kind;
  logic [COORD_BITS-1:0] adv_col;
  logic [COORD_BITS-1:0] nl_row;

  // Wrap a row to zero when a cell placed there would reach the screen height.
  function automatic logic [COORD_BITS-1:0] wrap_row(input logic [COORD_BITS-1:0] r,
                                                    input logic [SCREEN_W-1:0] h);
    logic [COORD_BITS-1:0] res;
    res = r;
    if (CMP_W'(r) + CMP_W'(CELL_HEIGHT) >= CMP_W'(h)) res = '0;
    return res;
  endfunction

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      opcode_q <= opcode_i;
      code_q   <= char_code_i;
      color_q  <= text_color_i;
      fidx_q   <= font_index_i;
      fbyte_q  <= font_byte_i;
    end
  end

  // Register file writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      bg_q     <= BG_RST;
      grows_q  <= GROWS_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_LINE_STRIDE:   stride_q <= cfg_data_i[STRIDE_W-1:0];
        REG_SCREEN_WIDTH:  width_q  <= cfg_data_i[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: height_q <= cfg_data_i[SCREEN_W-1:0];
        REG_BG_COLOR:      bg_q     <= cfg_data_i[COLOR_W-1:0];
        REG_GLYPH_ROWS:    grows_q  <= cfg_data_i[GROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode the latched item against the current cursor.
  always_comb begin
    kind = KIND_NONE;
    case (opcode_e'(opcode_q))
      OP_LOAD: kind = KIND_LOAD;
      OP_HOME: kind = KIND_HOME;
      OP_PRINT: begin
        if (code_q == CHAR_NEWLINE) begin
          kind = KIND_NEWLINE;
        end else if (code_q == CHAR_BACKSPACE) begin
          kind = (cur_col_q >= COORD_BITS'(CELL_WIDTH)) ? KIND_BS : KIND_NONE;
        end else begin
          kind = KIND_PRINT;
        end
      end
      default: kind = KIND_NONE;
    endcase
  end

  assign status_o.kind = kind;
  assign status_o.last = (rowcnt_q == nlast_q);

  // Row count of this character, less one.
  always_comb begin
    if (kind == KIND_BS) begin
      nlast_d = ROW_W'(BS_ROWS - 1);
    end else if (grows_q == '0) begin
      nlast_d = '0;
    end else if (grows_q > GROWS_W'(MAX_ROWS)) begin
      nlast_d = ROW_W'(MAX_ROWS - 1);
    end else begin
      nlast_d = ROW_W'(grows_q - GROWS_W'(1));
    end
  end

  // Cursor updates: control characters at decode, print advance after the base.
  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    adv_col   = cur_col_q + COORD_BITS'(CELL_WIDTH);
    nl_row    = cur_row_q + COORD_BITS'(CELL_HEIGHT);
    if (cmd_i.exec) begin
      case (kind)
        KIND_HOME: begin
          cur_col_d = '0;
          cur_row_d = '0;
        end
        KIND_NEWLINE: begin
          cur_col_d = '0;
          cur_row_d = wrap_row(nl_row, height_q);
        end
        KIND_BS: cur_col_d = cur_col_q - COORD_BITS'(CELL_WIDTH);
        default: ;
      endcase
    end else if (cmd_i.base && !is_bs_q) begin
      if (CMP_W'(adv_col) + CMP_W'(CELL_WIDTH) >= CMP_W'(width_q)) begin
        cur_col_d = '0;
        cur_row_d = wrap_row(nl_row, height_q);
      end else begin
        cur_col_d = adv_col;
        cur_row_d = wrap_row(cur_row_q, height_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
    end
  end

  // Row sequencing and address arithmetic.
  assign prod_full = cur_row_q * stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rowcnt_q <= '0;
      nlast_q  <= '0;
      is_bs_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      rowcnt_q <= '0;
      nlast_q  <= nlast_d;
      is_bs_q  <= (kind == KIND_BS);
    end else if (cmd_i.step) begin
      rowcnt_q <= rowcnt_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) prod_q <= ADDR_W'(prod_full);
    if (cmd_i.base) begin
      addr_q <= prod_q + ADDR_W'(cur_col_q);
    end else if (cmd_i.step) begin
      addr_q <= addr_q + ADDR_W'(stride_q);
    end
  end

  // Font store: one write port for loads, one registered read that looks
  // ahead to the next row on an accepted beat.
  assign font_we = cmd_i.exec && (kind == KIND_LOAD);
  assign rd_row  = cmd_i.step ? rowcnt_q + ROW_W'(1) : rowcnt_q;
  assign font_ra = font_fold({code_q, rd_row});

  always_ff @(posedge clk_i) begin
    if (font_we) font_mem[font_fold(fidx_q)] <= fbyte_q;
    glyph_q <= font_mem[font_ra];
  end

  // Row write payload; a backspace blanks the cell in the background color.
  assign row_address_o = addr_q;
  assign glyph_bits_o  = is_bs_q ? '0 : glyph_q;
  assign foreground_o  = is_bs_q ? bg_q : color_q;
  assign background_o  = bg_q;
  assign last_row_o    = (rowcnt_q == nlast_q);

endmodule
`default_nettype wire

### hw/rtl/tcgr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_checker
// Port-level checks of the glyph renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_glyph_renderer_top_macros.svh"

module tcgr_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            in_valid_i,
  input wire                            in_ready_i,
  input wire                            out_valid_i,
  input wire                            out_ready_i,
  input wire                            out_last_i,
  input wire [tcgr_pkg::ADDR_W-1:0]     out_addr_i,
  input wire [tcgr_pkg::GLYPH_W-1:0]    out_glyph_i
);

  // No new item is taken while row beats of the current one are pending.
  `TCGR_ASSERT_IMPL(a_busy_no_accept, clk_i, rst_ni, out_valid_i, !in_ready_i,
                    "input accepted while rows pending")

  // No row beat is offered in the cycle after an item is accepted.
  `TCGR_ASSERT_NEXT(a_no_early_row, clk_i, rst_ni, in_valid_i && in_ready_i,
                    !out_valid_i, "row beat right after accept")

  // The final row beat ends the character.
  `TCGR_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, out_valid_i && out_ready_i && out_last_i,
                    !out_valid_i, "row beat after the last row")

  // A stalled row beat holds its payload.
  `TCGR_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(out_addr_i) && $stable(out_glyph_i),
                    "stalled row beat changed")

endmodule

bind text_console_glyph_renderer_top tcgr_checker u_tcgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_if.valid),
  .in_ready_i  (item_if.ready),
  .out_valid_i (row_if.valid),
  .out_ready_i (row_if.ready),
  .out_last_i  (row_if.last_row),
  .out_addr_i  (row_if.row_address),
  .out_glyph_i (row_if.glyph_bits)
);
`default_nettype wire

### tb/text_console_glyph_renderer_top_tb.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top_tb
// Self-checking bench for the text console glyph renderer. A driver streams
// print, font-load, home and ignored items; the register channel sets up the
// console geometry between phases. A predictor keeps its own cursor, font
// copy and register copy, and a monitor checks every row write beat in order.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcgr_pkg::*;

  localparam int unsigned GLYPH_STRIDE     = 16;
  localparam int unsigned COORD_MASK       = (1 << COORD_BITS) - 1;
  localparam int unsigned QUIET_LIMIT      = 4000;
  localparam int unsigned SETTLE_CYCLES    = 12;
  localparam int unsigned LONG_HOLD_AFTER  = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_PER_PHASE = 8;
  localparam int unsigned NEWLINE_RUN      = 130;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct {
    opcode_e              op;
    logic [CODE_W-1:0]    code;
    logic [COLOR_W-1:0]   color;
    logic [FIDX_W-1:0]    fidx;
    logic [GLYPH_W-1:0]   fbyte;
  } console_item_t;

  typedef struct {
    logic [ADDR_W-1:0]    addr;
    logic [GLYPH_W-1:0]   bits;
    logic [COLOR_W-1:0]   fg;
    logic [COLOR_W-1:0]   bg;
    logic                 last;
  } row_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tcgr_item_if item_ch ();
  tcgr_row_if  row_ch ();
  tcgr_cfg_if  cfg_ch ();

  text_console_glyph_renderer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_if(item_ch),
    .row_if (row_ch),
    .cfg_if (cfg_ch)
  );

  always #1 clk_i = ~clk_i;

  // Predictor copy of the registers, the cursor and the font store.
  logic [STRIDE_W-1:0] cfg_stride;
  logic [SCREEN_W-1:0] cfg_width;
  logic [SCREEN_W-1:0] cfg_height;
  logic [COLOR_W-1:0]  cfg_bg;
  logic [GROWS_W-1:0]  cfg_rows;
  int unsigned         cur_col;
  int unsigned         cur_row;
  logic [GLYPH_W-1:0]  font_mem [FONT_DEPTH];

  console_item_t pending_items [$];
  row_write_t    expected_rows [$];
  logic [CODE_W-1:0] glyph_codes [$];

  int unsigned mismatch_count = 0;
  int unsigned rows_seen = 0;
  int unsigned quiet_cycles = 0;

  // Expected row writes.

  function automatic void push_row(int unsigned r, logic [GLYPH_W-1:0] bits,
                                   logic [COLOR_W-1:0] fg, bit last);
    row_write_t  w;
    int unsigned pixel;
    pixel  = (cur_row + r) * cfg_stride + cur_col;
    w.addr = pixel[ADDR_W-1:0];
    w.bits = bits;
    w.fg   = fg;
    w.bg   = cfg_bg;
    w.last = last;
    expected_rows.push_back(w);
  endfunction

  function automatic void wrap_screen_rows();
    if (cur_row + CELL_HEIGHT >= cfg_height) cur_row = 0;
  endfunction

  // Work out the rows one accepted item writes and move the cursor.
  function automatic void render_item(console_item_t it);
    int unsigned rows;
    case (it.op)
      OP_LOAD: font_mem[it.fidx % FONT_DEPTH] = it.fbyte;
      OP_HOME: begin
        cur_col = 0;
        cur_row = 0;
      end
      OP_PRINT: begin
        if (it.code == CHAR_NEWLINE) begin
          cur_col = 0;
          cur_row = (cur_row + CELL_HEIGHT) & COORD_MASK;
          wrap_screen_rows();
        end else if (it.code == CHAR_BACKSPACE) begin
          // Backspace at the left edge does nothing at all.
          if (cur_col >= CELL_WIDTH) begin
            cur_col = (cur_col - CELL_WIDTH) & COORD_MASK;
            rows = (CELL_HEIGHT < MAX_ROWS) ? CELL_HEIGHT : MAX_ROWS;
            for (int unsigned r = 0; r < rows; r++)
              push_row(r, '0, cfg_bg, r + 1 == rows);
          end
        end else begin
          // A row count of zero draws one row; counts above the glyph height clamp.
          rows = (cfg_rows == 0) ? 1 : (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
          for (int unsigned r = 0; r < rows; r++)
            push_row(r, font_mem[(it.code * GLYPH_STRIDE + r) % FONT_DEPTH], it.color,
                     r + 1 == rows);
          cur_col = (cur_col + CELL_WIDTH) & COORD_MASK;
          if (cur_col + CELL_WIDTH >= cfg_width) begin
            cur_col = 0;
            cur_row = (cur_row + CELL_HEIGHT) & COORD_MASK;
          end
          wrap_screen_rows();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LINE_STRIDE:   cfg_stride = data[STRIDE_W-1:0];
      REG_SCREEN_WIDTH:  cfg_width  = data[SCREEN_W-1:0];
      REG_SCREEN_HEIGHT: cfg_height = data[SCREEN_W-1:0];
      REG_BG_COLOR:      cfg_bg     = data[COLOR_W-1:0];
      REG_GLYPH_ROWS:    cfg_rows   = data[GROWS_W-1:0];
      default: ;
    endcase
  endfunction

  // Stimulus generation.

  function automatic void queue_item(opcode_e op, logic [CODE_W-1:0] code,
                                     logic [COLOR_W-1:0] color, logic [FIDX_W-1:0] fidx,
                                     logic [GLYPH_W-1:0] fbyte);
    console_item_t it;
    it.op    = op;
    it.code  = code;
    it.color = color;
    it.fidx  = fidx;
    it.fbyte = fbyte;
    pending_items.push_back(it);
  endfunction

  // Load every row of a glyph so that it can be printed at any row count.
  function automatic void queue_glyph(logic [CODE_W-1:0] code);
    for (int r = 0; r < GLYPH_STRIDE; r++)
      queue_item(OP_LOAD, CODE_W'($urandom), $urandom, {code, 4'(r)}, GLYPH_W'($urandom));
    glyph_codes.push_back(code);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_glyph();
    return glyph_codes[$urandom_range(0, glyph_codes.size() - 1)];
  endfunction

  // One random item; returns 0 for an OP_NONE item, which the block ignores.
  function automatic int queue_random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 52)
      queue_item(OP_PRINT, pick_glyph(), pick_color(), FIDX_W'($urandom), GLYPH_W'($urandom));
    else if (pick < 64)
      queue_item(OP_PRINT, CHAR_BACKSPACE, $urandom, FIDX_W'($urandom), GLYPH_W'($urandom));
    else if (pick < 72)
      queue_item(OP_PRINT, CHAR_NEWLINE, $urandom, FIDX_W'($urandom), GLYPH_W'($urandom));
    else if (pick < 76)
      queue_item(OP_HOME, CODE_W'($urandom), $urandom, FIDX_W'($urandom), GLYPH_W'($urandom));
    else if (pick < 88)
      queue_item(OP_LOAD, CODE_W'($urandom), $urandom, FIDX_W'($urandom), GLYPH_W'($urandom));
    else if (pick < 92)
      queue_glyph(CODE_W'($urandom));
    else begin
      queue_item(OP_NONE, CODE_W'($urandom), $urandom, FIDX_W'($urandom), GLYPH_W'($urandom));
      return 0;
    end
    return 1;
  endfunction

  function automatic void queue_random_run(int unsigned count);
    int unsigned n;
    n = 0;
    while (n < count) n += queue_random_item();
  endfunction

  // Register channel: one write per call, valid lowered on the accepting edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    apply_reg(idx, data);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_console(logic [CFG_DATA_W-1:0] stride, logic [CFG_DATA_W-1:0] width,
                             logic [CFG_DATA_W-1:0] height, logic [CFG_DATA_W-1:0] bg,
                             logic [CFG_DATA_W-1:0] rows);
    write_reg(REG_LINE_STRIDE, stride);
    write_reg(REG_SCREEN_WIDTH, width);
    write_reg(REG_SCREEN_HEIGHT, height);
    write_reg(REG_BG_COLOR, bg);
    write_reg(REG_GLYPH_ROWS, rows);
  endtask

  // Wait until every item is taken and every row write has arrived, then let
  // the block finish any item that writes no rows.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || item_ch.valid || expected_rows.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mismatch reporting and the row check.

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("[%0t] row beat %0d: %s got 0x%0h expected 0x%0h", $time, rows_seen, what,
             got, want);
  endtask

  task automatic check_row_beat();
    row_write_t want;
    if (expected_rows.size() == 0) begin
      report_mismatch("unexpected beat, row_address", row_ch.row_address, '0);
      return;
    end
    want = expected_rows.pop_front();
    if (row_ch.row_address !== want.addr)
      report_mismatch("row_address", row_ch.row_address, want.addr);
    if (row_ch.glyph_bits !== want.bits)
      report_mismatch("glyph_bits", row_ch.glyph_bits, want.bits);
    if (row_ch.foreground !== want.fg)
      report_mismatch("foreground", row_ch.foreground, want.fg);
    if (row_ch.background !== want.bg)
      report_mismatch("background", row_ch.background, want.bg);
    if (row_ch.last_row !== want.last)
      report_mismatch("last_row", row_ch.last_row, want.last);
  endtask

  // Item driver: predicts each accepted beat, then offers the next one after a gap.
  console_item_t offered;
  int unsigned   gap_left = 0;
  int unsigned   burst_left = 0;

  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 88) begin
      burst_left = $urandom_range(20, 40);
      return 0;
    end
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) render_item(offered);
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          offered = pending_items.pop_front();
          item_ch.opcode     <= offered.op;
          item_ch.char_code  <= offered.code;
          item_ch.text_color <= offered.color;
          item_ch.font_index <= offered.fidx;
          item_ch.font_byte  <= offered.fbyte;
          item_ch.valid      <= 1'b1;
          gap_left = pick_gap();
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Row monitor: checks each beat and stalls at random, once for a long stretch.
  int unsigned hold_left = 0;
  int unsigned run_left = 0;
  bit          long_hold_done = 1'b0;
  logic        ready_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ch.ready <= 1'b0;
    end else begin
      if (row_ch.valid && row_ch.ready) begin
        check_row_beat();
        rows_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (run_left != 0) begin
        run_left--;
        ready_next = 1'b1;
      end else if (!long_hold_done && rows_seen >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
        ready_next = 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
            run_left = $urandom_range(0, 7);
            ready_next = 1'b1;
          end
          11, 12, 13, 14, 15, 16: begin
            hold_left = $urandom_range(0, 2);
            ready_next = 1'b0;
          end
          17, 18: begin
            run_left = $urandom_range(20, 60);
            ready_next = 1'b1;
          end
          default: begin
            hold_left = $urandom_range(10, 40);
            ready_next = 1'b0;
          end
        endcase
      end
      row_ch.ready <= ready_next;
    end
  end

  // Watchdog: ends the run when no channel has moved a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (item_ch.valid && item_ch.ready) || (row_ch.valid && row_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("text_console_glyph_renderer_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    item_ch.valid      = 1'b0;
    item_ch.opcode     = OP_NONE;
    item_ch.char_code  = '0;
    item_ch.text_color = '0;
    item_ch.font_index = '0;
    item_ch.font_byte  = '0;
    row_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    rst_ni             = 1'b0;

    cfg_stride = STRIDE_RST;
    cfg_width  = WIDTH_RST;
    cfg_height = HEIGHT_RST;
    cfg_bg     = BG_RST;
    cfg_rows   = GROWS_RST;
    cur_col    = 0;
    cur_row    = 0;
    for (int i = 0; i < FONT_DEPTH; i++) font_mem[i] = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset register values.
    queue_item(OP_NONE, '1, '1, '1, '1);
    queue_item(OP_PRINT, CHAR_BACKSPACE, '1, '0, '0);
    queue_glyph(8'h00);
    queue_glyph(8'hFF);
    queue_item(OP_PRINT, 8'h00, '0, '1, '1);
    queue_item(OP_PRINT, 8'hFF, '1, '0, '0);
    queue_item(OP_PRINT, CHAR_BACKSPACE, '0, '0, '0);
    queue_item(OP_LOAD, '0, '0, 12'd0, 8'h80);
    queue_item(OP_LOAD, '1, '1, 12'd1, 8'h01);
    queue_item(OP_PRINT, 8'h00, 32'hA5A5_5A5A, '0, '0);
    queue_item(OP_PRINT, CHAR_NEWLINE, '1, '1, '1);
    queue_item(OP_PRINT, 8'hFF, 32'h0000_FFFF, '1, '1);
    queue_item(OP_PRINT, CHAR_BACKSPACE, '1, '1, '1);
    queue_item(OP_PRINT, CHAR_BACKSPACE, '1, '1, '1);
    queue_item(OP_HOME, '1, '1, '1, '1);
    queue_item(OP_PRINT, 8'h00, '1, '0, '0);
    queue_random_run(RANDOM_PER_PHASE);
    wait_drained();

    // Narrowest screen, a stride of 8192, one-row glyphs, all-ones background.
    set_console(32'd8192, 32'd16, 32'd32, '1, 32'd1);
    queue_glyph(CODE_W'($urandom));
    queue_random_run(RANDOM_PER_PHASE);
    wait_drained();

    // Unit stride, a 4096 by 4096 screen, full glyphs, zero background.
    set_console(32'd1, 32'd4096, 32'd4096, '0, 32'd16);
    write_reg(REG_UNUSED_HI, '1);
    queue_random_run(RANDOM_PER_PHASE);
    wait_drained();

    // Random geometry with stray upper data bits and a row count of zero.
    set_console({$urandom} & 32'hFFFF_C000 | $urandom_range(1, 8192),
                {$urandom} & 32'hFFFF_E000 | $urandom_range(16, 4096),
                $urandom_range(32, 4096), $urandom, 32'hFFFF_FFE0);
    write_reg(REG_UNUSED_LO, $urandom);
    queue_random_run(RANDOM_PER_PHASE);
    wait_drained();

    // All-ones writes: largest stride and screen, row count above a glyph.
    // A long newline run pushes the row address past the address range and wraps it.
    set_console('1, '1, '1, $urandom, '1);
    queue_item(OP_HOME, '0, '0, '0, '0);
    for (int k = 0; k < NEWLINE_RUN; k++) begin
      queue_item(OP_PRINT, CHAR_NEWLINE, $urandom, FIDX_W'($urandom), GLYPH_W'($urandom));
      if (k % 16 == 15)
        queue_item(OP_PRINT, pick_glyph(), pick_color(), FIDX_W'($urandom), GLYPH_W'($urandom));
    end
    queue_random_run(RANDOM_PER_PHASE / 2);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("text_console_glyph_renderer_top verification clean");
    end else begin
      $display("text_console_glyph_renderer_top verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tcgr_pkg.sv
hw/rtl/tcgr_ifs.sv
hw/rtl/tcgr_ctrl.sv
hw/rtl/tcgr_dp.sv
hw/rtl/text_console_glyph_renderer_top.sv
hw/rtl/tcgr_checker.sv
tb/text_console_glyph_renderer_top_tb.sv
